// ===== rtl/bad_pkg.sv =====
// ----------------------------------------------------------------------------
// bad_pkg
// Shared types and constants for the box accumulate and distance block.
// ----------------------------------------------------------------------------
`default_nettype none

package bad_pkg;

  localparam int COORD_BITS_DEF = 24;
  localparam int FIELD_BITS     = 24;
  localparam int NUM_AXES       = 3;
  localparam int DIST_BITS      = 53;
  localparam int CMD_BITS       = 2;
  localparam int IN_DATA_W      = NUM_AXES * FIELD_BITS;
  localparam int OUT_DATA_W     = ((DIST_BITS + 7) / 8) * 8;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_ADD    = 2'd0,
    CMD_SIGNED = 2'd1,
    CMD_CENTER = 2'd2
  } cmd_e;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } lane_en_t;

  typedef struct packed {
    logic en;
    logic signed_q;
    logic empty;
  } merge_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/bad_lane.sv =====
// ----------------------------------------------------------------------------
// bad_lane
// One axis: box corner registers and a three-stage difference, square and
// per-axis combine pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module bad_lane #(
  parameter int COORD_BITS = bad_pkg::COORD_BITS_DEF,
  localparam int SQ_W = 2 * COORD_BITS + 3
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic [bad_pkg::FIELD_BITS-1:0]   coord_i,
  input  wire logic                             add_i,
  input  wire logic                             box_valid_i,
  input  wire bad_pkg::lane_en_t                en_i,
  output logic                                  outside_o,
  output logic [SQ_W-1:0]                       min_sq_o,
  output logic [SQ_W-1:0]                       out_sq_o,
  output logic [SQ_W-1:0]                       ctr_sq_o
);

  localparam int CB = COORD_BITS;

  logic signed [CB-1:0]   p;
  logic signed [CB-1:0]   lo_q, lo_d, hi_q, hi_d;

  logic signed [CB:0]     dl_d, dh_d;
  logic signed [CB+1:0]   dc_d;
  logic signed [CB:0]     dl_q, dh_q;
  logic signed [CB+1:0]   dc_q;
  logic                   below_q1, above_q1;

  logic signed [CB+1:0]   el, eh;
  logic signed [2*CB+3:0] pl, ph, pc;
  logic [SQ_W-1:0]        sql_q, sqh_q, sqc_q;
  logic                   below_q2, above_q2;

  assign p = coord_i[CB-1:0];

  always_comb begin
    lo_d = lo_q;
    hi_d = hi_q;
    if (add_i) begin
      if (!box_valid_i) begin
        lo_d = p;
        hi_d = p;
      end else begin
        if (p < lo_q) lo_d = p;
        if (p > hi_q) hi_d = p;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_q <= '0;
      hi_q <= '0;
    end else begin
      lo_q <= lo_d;
      hi_q <= hi_d;
    end
  end

  assign dl_d = {p[CB-1], p} - {lo_q[CB-1], lo_q};
  assign dh_d = {p[CB-1], p} - {hi_q[CB-1], hi_q};
  assign dc_d = {p[CB-1], p, 1'b0} - {lo_q[CB-1], lo_q[CB-1], lo_q}
              - {hi_q[CB-1], hi_q[CB-1], hi_q};

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      dl_q     <= dl_d;
      dh_q     <= dh_d;
      dc_q     <= dc_d;
      below_q1 <= (p < lo_q);
      above_q1 <= (p > hi_q);
    end
  end

  assign el = {dl_q[CB], dl_q};
  assign eh = {dh_q[CB], dh_q};
  assign pl = el * el;
  assign ph = eh * eh;
  assign pc = dc_q * dc_q;

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      sql_q    <= pl[SQ_W-1:0];
      sqh_q    <= ph[SQ_W-1:0];
      sqc_q    <= pc[SQ_W-1:0];
      below_q2 <= below_q1;
      above_q2 <= above_q1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      outside_o <= below_q2 | above_q2;
      min_sq_o  <= (sql_q < sqh_q) ? sql_q : sqh_q;
      out_sq_o  <= below_q2 ? sql_q : (above_q2 ? sqh_q : '0);
      ctr_sq_o  <= sqc_q;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    box_valid_i |-> (lo_q <= hi_q))
    else $error("Box lower corner exceeds upper corner.");

endmodule

`default_nettype wire

// ===== rtl/bad_merge.sv =====
// ----------------------------------------------------------------------------
// bad_merge
// Combines the three lane results into the final distance and registers it.
// ----------------------------------------------------------------------------
`default_nettype none

module bad_merge #(
  parameter int COORD_BITS = bad_pkg::COORD_BITS_DEF,
  localparam int SQ_W = 2 * COORD_BITS + 3
) (
  input  wire logic                                         clk_i,
  input  wire bad_pkg::merge_ctl_t                          ctl_i,
  input  wire logic [bad_pkg::NUM_AXES-1:0]                 outside_i,
  input  wire logic [bad_pkg::NUM_AXES-1:0][SQ_W-1:0]       min_sq_i,
  input  wire logic [bad_pkg::NUM_AXES-1:0][SQ_W-1:0]       out_sq_i,
  input  wire logic [bad_pkg::NUM_AXES-1:0][SQ_W-1:0]       ctr_sq_i,
  output logic [bad_pkg::DIST_BITS-1:0]                     dist_o,
  output logic                                              empty_o
);

  localparam int RAW_W  = 2 * COORD_BITS + 7;
  localparam int WORK_W = (RAW_W > bad_pkg::DIST_BITS) ? RAW_W : bad_pkg::DIST_BITS;

  logic [SQ_W-1:0]          m01, mmin;
  logic [WORK_W-1:0]        osum, csum;
  logic signed [WORK_W-1:0] res;

  assign m01  = (min_sq_i[0] < min_sq_i[1]) ? min_sq_i[0] : min_sq_i[1];
  assign mmin = (m01 < min_sq_i[2]) ? m01 : min_sq_i[2];
  assign osum = WORK_W'(out_sq_i[0]) + WORK_W'(out_sq_i[1]) + WORK_W'(out_sq_i[2]);
  assign csum = WORK_W'(ctr_sq_i[0]) + WORK_W'(ctr_sq_i[1]) + WORK_W'(ctr_sq_i[2]);

  always_comb begin
    if (ctl_i.empty) begin
      res = '0;
    end else if (ctl_i.signed_q) begin
      if (|outside_i) begin
        res = osum << 2;
      end else begin
        res = -(WORK_W'(mmin) << 2);
      end
    end else begin
      res = csum;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      dist_o  <= res[bad_pkg::DIST_BITS-1:0];
      empty_o <= ctl_i.empty;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/box_accumulate_and_distance_top.sv =====
// ----------------------------------------------------------------------------
// box_accumulate_and_distance_top
// Axis-aligned bounding box accumulator with point distance queries.
// ----------------------------------------------------------------------------
// The block takes one beat per clock cycle when not stalled. An add beat
// grows the box and gives no result; the box update is visible to the very
// next beat. A query result passes through three per-axis lane stages
// (difference, square, combine) and the merge output register; each stage
// holds only while the stage after it is full and stalled, so bubbles close
// up. Distances are four times the squared distance, negated for a signed
// query inside the box; an empty-box query returns zero with tuser set.
// ----------------------------------------------------------------------------
`default_nettype none

module box_accumulate_and_distance_top #(
  parameter int COORD_BITS = bad_pkg::COORD_BITS_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  // Fields from bit 0: coord_x[23:0], coord_y[23:0], coord_z[23:0].
  input  wire logic [bad_pkg::IN_DATA_W-1:0]     s_axis_tdata_i,
  // Fields from bit 0: command[1:0].
  input  wire logic [bad_pkg::CMD_BITS-1:0]      s_axis_tuser_i,
  output logic                                   m_axis_tvalid_o,
  input  wire logic                              m_axis_tready_i,
  // Fields from bit 0: distance_sq[52:0], zero fill.
  output logic [bad_pkg::OUT_DATA_W-1:0]         m_axis_tdata_o,
  // Fields from bit 0: box_empty.
  output logic [0:0]                             m_axis_tuser_o
);

  localparam int SQ_W = 2 * COORD_BITS + 3;
  localparam int NA   = bad_pkg::NUM_AXES;
  localparam int FB   = bad_pkg::FIELD_BITS;

  bad_pkg::cmd_e       cmd;
  logic                accept, is_query, is_add;
  logic                box_valid_q, box_valid_d;
  logic                v1_q, v2_q, v3_q, v4_q;
  logic                r1, r2, r3, r4;
  logic                sg1_q, sg2_q, sg3_q;
  logic                em1_q, em2_q, em3_q;
  bad_pkg::lane_en_t   lane_en;
  bad_pkg::merge_ctl_t mctl;
  logic [bad_pkg::DIST_BITS-1:0] dist_sq;
  logic                empty;

  logic [NA-1:0]           outside;
  logic [NA-1:0][SQ_W-1:0] min_sq, out_sq, ctr_sq;

  assign cmd = bad_pkg::cmd_e'(s_axis_tuser_i);

  always_comb begin
    case (cmd)
      bad_pkg::CMD_SIGNED, bad_pkg::CMD_CENTER: is_query = 1'b1;
      default:                                  is_query = 1'b0;
    endcase
  end

  assign r4 = !v4_q || m_axis_tready_i;
  assign r3 = !v3_q || r4;
  assign r2 = !v2_q || r3;
  assign r1 = !v1_q || r2;

  assign s_axis_tready_o = r1;
  assign accept          = s_axis_tvalid_i && r1;
  assign is_add          = accept && (cmd == bad_pkg::CMD_ADD);
  assign box_valid_d     = box_valid_q || is_add;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_valid_q <= 1'b0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
    end else begin
      box_valid_q <= box_valid_d;
      if (r1) v1_q <= accept && is_query;
      if (r2) v2_q <= v1_q;
      if (r3) v3_q <= v2_q;
      if (r4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (r1) begin
      sg1_q <= (cmd == bad_pkg::CMD_SIGNED);
      em1_q <= !box_valid_q;
    end
    if (r2) begin
      sg2_q <= sg1_q;
      em2_q <= em1_q;
    end
    if (r3) begin
      sg3_q <= sg2_q;
      em3_q <= em2_q;
    end
  end

  assign lane_en.s1 = r1;
  assign lane_en.s2 = r2;
  assign lane_en.s3 = r3;

  for (genvar a = 0; a < NA; a++) begin : g_lane
    bad_lane #(
      .COORD_BITS (COORD_BITS)
    ) u_lane (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .coord_i     (s_axis_tdata_i[a*FB +: FB]),
      .add_i       (is_add),
      .box_valid_i (box_valid_q),
      .en_i        (lane_en),
      .outside_o   (outside[a]),
      .min_sq_o    (min_sq[a]),
      .out_sq_o    (out_sq[a]),
      .ctr_sq_o    (ctr_sq[a])
    );
  end

  assign mctl.en       = r4;
  assign mctl.signed_q = sg3_q;
  assign mctl.empty    = em3_q;

  bad_merge #(
    .COORD_BITS (COORD_BITS)
  ) u_merge (
    .clk_i     (clk_i),
    .ctl_i     (mctl),
    .outside_i (outside),
    .min_sq_i  (min_sq),
    .out_sq_i  (out_sq),
    .ctr_sq_i  (ctr_sq),
    .dist_o    (dist_sq),
    .empty_o   (empty)
  );

  assign m_axis_tvalid_o   = v4_q;
  assign m_axis_tdata_o    = bad_pkg::OUT_DATA_W'(dist_sq);
  assign m_axis_tuser_o[0] = empty;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_add |=> box_valid_q)
    else $error("Box not marked valid after an add beat.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    box_valid_q |=> box_valid_q)
    else $error("Box valid flag dropped without reset.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (v1_q && v2_q && v3_q && v4_q))
    else $error("Input stalled while the pipeline has a bubble.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o[0]) |-> (m_axis_tdata_o == '0))
    else $error("Empty-box result carries a nonzero distance.");

endmodule

`default_nettype wire
